// ===== hw/rtl/calendar_date_arithmetic_assert.svh =====
// Assertion macros for the calendar date arithmetic block.
`ifndef CALENDAR_DATE_ARITHMETIC_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_ASSERT_SVH
`ifndef SYNTHESIS
`define CDA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CDA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CDA_ASSERT_IMP(label, clk, rst, ante, cons)
`define CDA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/cda_pkg.sv =====
// Types, codes and calendar tables shared by the date arithmetic pipeline.
`default_nettype none
package cda_pkg;

   localparam logic FUNC_DIFF = 1'b0;
   localparam logic FUNC_ADD  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
   localparam logic [1:0] STATUS_RANGE    = 2'd2;

   localparam logic [17:0] DAYS_400 = 18'd146097;
   localparam logic [15:0] DAYS_100 = 16'd36524;
   localparam logic [10:0] DAYS_4   = 11'd1461;
   localparam logic [8:0]  DAYS_1   = 9'd365;

   localparam logic [22:0] DIFF_LIMIT     = 23'd4194303;
   localparam logic [16:0] YEAR_FIELD_MAX = 17'd16383;

   typedef struct packed {
      logic        func;
      logic [4:0]  a_day;
      logic [3:0]  a_month;
      logic [13:0] a_year;
      logic [4:0]  b_day;
      logic [3:0]  b_month;
      logic [13:0] b_year;
      logic [21:0] add_count;
   } cda_req_type;

   typedef struct packed {
      logic signed [22:0] day_difference;
      logic [4:0]         result_day;
      logic [3:0]         result_month;
      logic [13:0]        result_year;
      logic [1:0]         status;
   } cda_rsp_type;

   // Handed from the day-number front end to the date split back end.
   typedef struct packed {
      logic               func;
      logic               bad;
      logic               diff_sat;
      logic signed [22:0] diff;
      logic [23:0]        day_sum;
   } cda_mid_type;

   // Days in the months before the given one of a common year.
   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] days;
      case (month)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd2:                                  len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:               len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
         4'd12:                                 len = 5'd31;
         default:                               len = 5'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cda_front.sv =====
// Front end: date checks, day numbers of both dates, difference and add sum.
`default_nettype none
module cda_front #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  cda_pkg::cda_req_type in_req,
   output logic                 out_valid,
   output cda_pkg::cda_mid_type out_mid
);
   import cda_pkg::*;

   localparam logic [16:0] MaxYear = 17'(MAX_YEAR);

   typedef struct packed {
      logic [13:0] p;
      logic [7:0]  qp;
      logic [22:0] p365;
      logic [4:0]  day;
      logic [3:0]  month;
      logic        year4;
      logic        range_ok;
   } s1_type;

   typedef struct packed {
      logic [22:0] num;
      logic        ok;
   } s2_type;

   logic        v1_ff, v2_ff, v3_ff;
   s1_type      s1_ff [2];
   s1_type      s1_in [2];
   s2_type      s2_ff [2];
   s2_type      s2_in [2];
   logic        func1_ff, func2_ff;
   logic [21:0] cnt1_ff, cnt2_ff;
   cda_mid_type mid_ff, mid_in;

   logic [4:0]  dd [2];
   logic [3:0]  mm [2];
   logic [13:0] yy [2];
   logic [26:0] qp_prod [2];
   logic [6:0]  rem [2];
   logic        leap [2];

   assign dd[0] = in_req.a_day;
   assign mm[0] = in_req.a_month;
   assign yy[0] = in_req.a_year;
   assign dd[1] = in_req.b_day;
   assign mm[1] = in_req.b_month;
   assign yy[1] = in_req.b_year;

   // Stage 1: p = year - 1, p / 100 by reciprocal, p * 365, range checks.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         s1_in[k].p        = yy[k] - 14'd1;
         qp_prod[k]        = 27'(s1_in[k].p) * 27'd5243;
         s1_in[k].qp       = qp_prod[k][26:19];
         s1_in[k].p365     = 23'(s1_in[k].p) * 23'd365;
         s1_in[k].day      = dd[k];
         s1_in[k].month    = mm[k];
         s1_in[k].year4    = (yy[k][1:0] == 2'b00);
         s1_in[k].range_ok = (mm[k] >= 4'd1) && (mm[k] <= 4'd12) && (yy[k] != 14'd0)
                             && ({3'b000, yy[k]} <= MaxYear);
      end
   end

   // Stage 2: leap year, day check and the day number counted from 1 January of year 1.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         rem[k]  = 7'(s1_ff[k].p - 14'(s1_ff[k].qp) * 14'd100);
         // The year is a century when p ends in 99, and a 400th year when p / 100 is 3 modulo 4.
         leap[k] = s1_ff[k].year4 && ((rem[k] != 7'd99) || (s1_ff[k].qp[1:0] == 2'b11));
         s2_in[k].ok  = s1_ff[k].range_ok && (s1_ff[k].day != 5'd0)
                        && (s1_ff[k].day <= month_length(s1_ff[k].month, leap[k]));
         s2_in[k].num = s1_ff[k].p365 + 23'(s1_ff[k].p >> 2) - 23'(s1_ff[k].qp)
                        + 23'(s1_ff[k].qp >> 2) + 23'(days_before(s1_ff[k].month))
                        + 23'(leap[k] && (s1_ff[k].month > 4'd2))
                        + 23'(s1_ff[k].day) - 23'd1;
      end
   end

   // Stage 3: signed difference with saturation, and the add sum.
   logic signed [23:0] diff_full;
   always_comb begin
      diff_full         = $signed({1'b0, s2_ff[0].num}) - $signed({1'b0, s2_ff[1].num});
      mid_in.func       = func2_ff;
      mid_in.bad        = !s2_ff[0].ok || ((func2_ff == FUNC_DIFF) && !s2_ff[1].ok);
      mid_in.day_sum    = 24'(s2_ff[0].num) + 24'(cnt2_ff);
      mid_in.diff_sat   = 1'b0;
      mid_in.diff       = diff_full[22:0];
      if (diff_full > $signed({1'b0, DIFF_LIMIT})) begin
         mid_in.diff_sat = 1'b1;
         mid_in.diff     = $signed(DIFF_LIMIT);
      end else if (diff_full < -$signed({1'b0, DIFF_LIMIT})) begin
         mid_in.diff_sat = 1'b1;
         mid_in.diff     = -$signed(DIFF_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         func1_ff <= in_req.func;
         func2_ff <= func1_ff;
         cnt1_ff  <= in_req.add_count;
         cnt2_ff  <= cnt1_ff;
         mid_ff   <= mid_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_mid   = mid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/cda_split.sv =====
// Back end: splits a day number into 400, 100, 4 and 1 year blocks, month and day.
`default_nettype none
module cda_split #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  cda_pkg::cda_mid_type in_mid,
   output logic                 out_valid,
   output cda_pkg::cda_rsp_type out_rsp
);
   import cda_pkg::*;

   localparam logic [16:0] MaxYear   = 17'(MAX_YEAR);
   // Rounded-up reciprocals; exact quotients over the operand ranges used here.
   localparam logic [25:0] Recip400  = 26'((64'd1 << 43) / 64'd146097 + 64'd1);
   localparam logic [17:0] Recip4    = 18'((64'd1 << 28) / 64'd1461 + 64'd1);

   logic        v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   cda_mid_type m4_ff, m5_ff, m6_ff, m7_ff, m8_ff, m9_ff;
   logic [6:0]  q400_4_ff, q400_5_ff, q400_6_ff, q400_7_ff, q400_8_ff;
   logic [17:0] r5_ff, r5_in;
   logic [1:0]  q100_6_ff, q100_7_ff, q100_8_ff, q100_in;
   logic [15:0] r6_ff, r7_ff, r6_in;
   logic [4:0]  q4_7_ff, q4_8_ff, q4_in;
   logic [10:0] r8_ff, r8_in;
   logic [8:0]  r9_ff, r9_in;
   logic [16:0] year9_ff, year9_in;
   logic        leap9_ff, leap9_in;
   logic [1:0]  q1_in;
   logic [6:0]  q400_in;
   cda_rsp_type rsp_ff, rsp_in;

   logic [49:0] prod400;
   logic [24:0] q400_days;
   logic [33:0] prod4;

   // Stage 4: number of whole 400-year blocks.
   always_comb begin
      prod400 = 50'(in_mid.day_sum) * 50'(Recip400);
      q400_in = prod400[49:43];
   end

   // Stage 5: remainder within the 400-year block.
   always_comb begin
      q400_days = 25'(q400_4_ff) * 25'(DAYS_400);
      r5_in     = 18'(25'(m4_ff.day_sum) - q400_days);
   end

   // Stage 6: centuries, capped at three so the last day of a 400th year stays in it.
   always_comb begin
      if (r5_ff >= 18'd109572) begin
         q100_in = 2'd3;
      end else if (r5_ff >= 18'd73048) begin
         q100_in = 2'd2;
      end else if (r5_ff >= 18'({2'b00, DAYS_100})) begin
         q100_in = 2'd1;
      end else begin
         q100_in = 2'd0;
      end
      r6_in = 16'(r5_ff - 18'(q100_in) * 18'({2'b00, DAYS_100}));
   end

   // Stage 7: four-year blocks.
   always_comb begin
      prod4 = 34'(r6_ff) * 34'(Recip4);
      q4_in = prod4[32:28];
   end

   // Stage 8: remainder within the four-year block.
   always_comb begin
      r8_in = 11'(r7_ff - 16'(q4_7_ff) * 16'(DAYS_4));
   end

   // Stage 9: single years, capped at three, then the year and its leap flag.
   always_comb begin
      if (r8_ff >= 11'd1095) begin
         q1_in = 2'd3;
      end else if (r8_ff >= 11'd730) begin
         q1_in = 2'd2;
      end else if (r8_ff >= 11'(DAYS_1)) begin
         q1_in = 2'd1;
      end else begin
         q1_in = 2'd0;
      end
      r9_in    = 9'(r8_ff - 11'(q1_in) * 11'(DAYS_1));
      year9_in = 17'd1 + 17'(q400_8_ff) * 17'd400 + 17'(q100_8_ff) * 17'd100
                 + 17'(q4_8_ff) * 17'd4 + 17'(q1_in);
      // Leap when last of the four years, unless a century that is not a 400th year.
      leap9_in = (q1_in == 2'd3) && ((q4_8_ff != 5'd24) || (q100_8_ff == 2'd3));
   end

   // Stage 10: month search over the year's month starts, and the result word.
   logic [3:0] month;
   logic [8:0] start;
   logic [8:0] start_m;
   always_comb begin
      month   = 4'd1;
      start   = 9'd0;
      start_m = 9'd0;
      for (int m = 2; m <= 12; m++) begin
         start_m = days_before(4'(m)) + 9'(leap9_ff && (m > 2));
         if (r9_ff >= start_m) begin
            month = 4'(m);
            start = start_m;
         end
      end
      rsp_in = '0;
      if (m9_ff.bad) begin
         rsp_in.status = STATUS_BAD_DATE;
      end else if (m9_ff.func == FUNC_DIFF) begin
         rsp_in.day_difference = m9_ff.diff;
         rsp_in.status         = m9_ff.diff_sat ? STATUS_RANGE : STATUS_OK;
      end else if ((year9_ff > MaxYear) || (year9_ff > YEAR_FIELD_MAX)) begin
         rsp_in.status = STATUS_RANGE;
      end else begin
         rsp_in.result_day   = 5'(r9_ff - start) + 5'd1;
         rsp_in.result_month = month;
         rsp_in.result_year  = year9_ff[13:0];
         rsp_in.status       = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (advance) begin
         v4_ff  <= in_valid;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m4_ff     <= in_mid;
         m5_ff     <= m4_ff;
         m6_ff     <= m5_ff;
         m7_ff     <= m6_ff;
         m8_ff     <= m7_ff;
         m9_ff     <= m8_ff;
         q400_4_ff <= q400_in;
         q400_5_ff <= q400_4_ff;
         q400_6_ff <= q400_5_ff;
         q400_7_ff <= q400_6_ff;
         q400_8_ff <= q400_7_ff;
         r5_ff     <= r5_in;
         q100_6_ff <= q100_in;
         q100_7_ff <= q100_6_ff;
         q100_8_ff <= q100_7_ff;
         r6_ff     <= r6_in;
         r7_ff     <= r6_ff;
         q4_7_ff   <= q4_in;
         q4_8_ff   <= q4_7_ff;
         r8_ff     <= r8_in;
         r9_ff     <= r9_in;
         year9_ff  <= year9_in;
         leap9_ff  <= leap9_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign out_valid = v10_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/calendar_date_arithmetic.sv =====
// Ten register stages; a word accepted into stage 1 shows on rsp_valid once it is held in stage 10.
// Throughput: one word per cycle, unless a result word is held by rsp_stall.
// A result word held by rsp_stall freezes every stage, and req_stall follows it.
// Reset: synchronous, clears the valid bit of every stage; no other state is kept.
`default_nettype none
`include "calendar_date_arithmetic_assert.svh"
module calendar_date_arithmetic #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cda_pkg::cda_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cda_pkg::cda_rsp_type rsp_data
);
   import cda_pkg::*;

   logic        advance;
   logic        mid_valid;
   cda_mid_type mid;

   // The whole pipeline moves unless a finished word is held at the output.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   cda_front #(.MAX_YEAR(MAX_YEAR)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (mid_valid),
      .out_mid   (mid)
   );

   cda_split #(.MAX_YEAR(MAX_YEAR)) u_split (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mid_valid),
      .in_mid    (mid),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

   `CDA_ASSERT_IMP(a_stall_only_when_held, clock, reset, req_stall, rsp_valid && rsp_stall)
   `CDA_ASSERT_NXT(a_held_word_stays, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `CDA_ASSERT_IMP(a_bad_date_zero, clock, reset, rsp_valid && (rsp_data.status == STATUS_BAD_DATE), (rsp_data.day_difference == 23'sd0) && (rsp_data.result_month == 4'd0))
   `CDA_ASSERT_IMP(a_date_excludes_diff, clock, reset, rsp_valid && (rsp_data.result_month != 4'd0), (rsp_data.result_day != 5'd0) && (rsp_data.day_difference == 23'sd0) && (rsp_data.result_month <= 4'd12))

endmodule
`default_nettype wire
